FILE: sv/dual_adpcm_rom_nibble_feeder_top_macros.svh
// ----------------------------------------------------------------------------
// ADPCM nibble feeder assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_ADPCM_ROM_NIBBLE_FEEDER_TOP_MACROS_SVH
`define DUAL_ADPCM_ROM_NIBBLE_FEEDER_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define ANF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define ANF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/anf_pkg.sv
// ----------------------------------------------------------------------------
// ADPCM nibble feeder package
// Shared codes, command word type and port widths.
// ----------------------------------------------------------------------------
package anf_pkg;

    localparam int ROM_ADDR_BITS_DEF = 16;
    localparam int BLOCK_SHIFT_DEF   = 9;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_REG_WRITE = 2'd0,
        OP_TICK      = 2'd1,
        OP_STATUS    = 2'd2,
        OP_LOAD      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_END   = 2'd1,
        REG_POS   = 2'd2,
        REG_STOP  = 2'd3
    } t_reg_sel;

    typedef enum logic [2:0] {
        K_START   = 3'd0,
        K_SET_END = 3'd1,
        K_SET_POS = 3'd2,
        K_STOP    = 3'd3,
        K_TICK    = 3'd4,
        K_STATUS  = 3'd5,
        K_LOAD    = 3'd6
    } t_kind;

    // classified command word passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        ch;
        logic [6:0]  blk;
        logic [15:0] rom_addr;
        logic [7:0]  rom_byte;
    } t_cmd;

endpackage

FILE: sv/dual_adpcm_rom_nibble_feeder_top.sv
// ----------------------------------------------------------------------------
// Dual ADPCM ROM nibble feeder
// Two-channel sample fetcher feeding 4-bit codes to two ADPCM decoders.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result word per clock when the
// output side is ready; each taken word passes through the command queue,
// then the result register. The rate is set by the back end, which runs one
// command per cycle while the output side is ready, against a sample memory
// of 2 << ROM_ADDR_BITS bytes with one write and one registered read port.
// The memory is not cleared and needs no start-up pass: a tick that reads a
// byte never loaded returns an arbitrary nibble.
module dual_adpcm_rom_nibble_feeder_top #(
    parameter int ROM_ADDR_BITS = anf_pkg::ROM_ADDR_BITS_DEF,
    parameter int BLOCK_SHIFT   = anf_pkg::BLOCK_SHIFT_DEF,
    parameter int QUEUE_DEPTH   = anf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // port_offset[2:0], write_data[10:3], channel[11], rom_address[27:12],
    // rom_byte[35:28], zero[39:36]
    input  logic [anf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op[1:0]
    input  logic [anf_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_channel[0], nibble_valid[1], nibble[5:2], reset_strobe[6],
    // reset_level[7], status[9:8], zero[15:10]
    output logic [anf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import anf_pkg::*;

    logic full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic head_valid;
    t_cmd head;

    anf_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    anf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    anf_back #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .BLOCK_SHIFT   (BLOCK_SHIFT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (o_m_axis_tdata)
    );

endmodule

FILE: sv/anf_front.sv
// ----------------------------------------------------------------------------
// ADPCM nibble feeder front end
// Accepts input words and classifies them into command words for the queue.
// ----------------------------------------------------------------------------
module anf_front (
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [anf_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [anf_pkg::IN_TUSER_W-1:0] i_s_tuser,
    input  logic                         i_full,
    output logic                         o_push,
    output anf_pkg::t_cmd                o_push_cmd
);
    import anf_pkg::*;

    t_op         op;
    logic [2:0]  offs;
    logic [7:0]  wdata;
    logic        chan;
    t_cmd        cmd;

    assign op    = t_op'(i_s_tuser[1:0]);
    assign offs  = i_s_tdata[2:0];
    assign wdata = i_s_tdata[10:3];
    assign chan  = i_s_tdata[11];

    always_comb begin
        cmd          = '0;
        cmd.blk      = wdata[6:0];
        cmd.rom_addr = i_s_tdata[27:12];
        cmd.rom_byte = i_s_tdata[35:28];
        unique case (op)
            OP_REG_WRITE: begin
                cmd.ch = offs[0];
                unique case (t_reg_sel'(offs[2:1]))
                    REG_START: cmd.kind = K_START;
                    REG_END:   cmd.kind = K_SET_END;
                    REG_POS:   cmd.kind = K_SET_POS;
                    REG_STOP:  cmd.kind = K_STOP;
                endcase
            end
            OP_TICK: begin
                cmd.kind = K_TICK;
                cmd.ch   = chan;
            end
            OP_STATUS: begin
                cmd.kind = K_STATUS;
                cmd.ch   = 1'b0;
            end
            OP_LOAD: begin
                cmd.kind = K_LOAD;
                cmd.ch   = chan;
            end
        endcase
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_push_cmd = cmd;

endmodule

FILE: sv/anf_queue.sv
// ----------------------------------------------------------------------------
// ADPCM nibble feeder command queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module anf_queue #(
    parameter int QUEUE_DEPTH = anf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  anf_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output anf_pkg::t_cmd o_head
);
    import anf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: sv/anf_back.sv
// ----------------------------------------------------------------------------
// ADPCM nibble feeder back end
// Runs commands against channel state and sample memory, holds the result.
// ----------------------------------------------------------------------------
module anf_back #(
    parameter int ROM_ADDR_BITS = anf_pkg::ROM_ADDR_BITS_DEF,
    parameter int BLOCK_SHIFT   = anf_pkg::BLOCK_SHIFT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  anf_pkg::t_cmd                   i_head,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [anf_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import anf_pkg::*;

    localparam int MEM_DEPTH = 2 << ROM_ADDR_BITS;

    typedef enum logic [1:0] {
        M_PLAIN,
        M_ROM,
        M_PEND
    } t_mode;

    logic [16:0] r_pos      [2];
    logic [15:0] r_end      [2];
    logic [1:0]  r_idle;
    logic [1:0]  r_pend_v;
    logic [3:0]  r_pend_nib [2];
    logic [7:0]  r_mem      [MEM_DEPTH];
    logic [7:0]  r_rom_q;

    logic        r_b_valid;
    logic        r_b_ch;
    t_mode       r_b_mode;
    logic        r_b_rs;
    logic        r_b_rl;
    logic [1:0]  r_b_status;

    logic        advance;
    logic        ch;
    logic [15:0] blk_addr;
    logic [16:0] pos;
    logic        at_end;
    logic [1:0]  n_idle;
    t_mode       n_mode;
    logic        n_rs;
    logic        n_rl;
    logic [3:0]  out_nib;

    assign advance  = !r_b_valid || i_m_tready;
    assign o_pop    = i_head_valid && advance;
    assign ch       = i_head.ch;
    assign blk_addr = 16'({9'd0, i_head.blk} << BLOCK_SHIFT);
    assign pos      = r_pos[ch];
    assign at_end   = (pos >= {1'b0, r_end[ch]}) || (pos[16:ROM_ADDR_BITS] != '0);

    always_comb begin
        n_idle = r_idle;
        n_mode = M_PLAIN;
        n_rs   = 1'b0;
        n_rl   = 1'b0;
        unique case (i_head.kind)
            K_START: begin
                n_idle[ch] = 1'b0;
                n_rs       = 1'b1;
            end
            K_STOP: begin
                n_idle[ch] = 1'b1;
                n_rs       = 1'b1;
                n_rl       = 1'b1;
            end
            K_TICK: begin
                if (at_end) begin
                    n_idle[ch] = 1'b1;
                    n_rs       = 1'b1;
                    n_rl       = 1'b1;
                end else if (r_pend_v[ch]) begin
                    n_mode = M_PEND;
                end else begin
                    n_mode = M_ROM;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '{default: '0};
            r_end     <= '{default: '0};
            r_idle    <= '0;
            r_pend_v  <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idle <= n_idle;
                case (i_head.kind)
                    K_SET_END: r_end[ch] <= blk_addr;
                    K_SET_POS: r_pos[ch] <= {1'b0, blk_addr};
                    K_TICK: begin
                        if (n_mode == M_PEND) begin
                            r_pend_v[ch] <= 1'b0;
                        end else if (n_mode == M_ROM) begin
                            r_pos[ch]    <= pos + 17'd1;
                            r_pend_v[ch] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (advance) begin
                r_b_valid <= o_pop;
            end
        end
    end

    // result payload, loaded when the slot moves
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_ch     <= ch;
            r_b_mode   <= n_mode;
            r_b_rs     <= n_rs;
            r_b_rl     <= n_rl;
            r_b_status <= n_idle;
        end
    end

    // sample memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_LOAD) begin
            r_mem[{ch, i_head.rom_addr[ROM_ADDR_BITS-1:0]}] <= i_head.rom_byte;
        end
        if (o_pop && n_mode == M_ROM) begin
            r_rom_q <= r_mem[{ch, pos[ROM_ADDR_BITS-1:0]}];
        end
    end

    // keep the low nibble once the high one has gone out
    always_ff @(posedge i_clk) begin
        if (r_b_valid && i_m_tready && r_b_mode == M_ROM) begin
            r_pend_nib[r_b_ch] <= r_rom_q[3:0];
        end
    end

    always_comb begin
        case (r_b_mode)
            M_ROM:   out_nib = r_rom_q[7:4];
            M_PEND:  out_nib = r_pend_nib[r_b_ch];
            default: out_nib = 4'd0;
        endcase
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = {6'd0, r_b_status, r_b_rl, r_b_rs, out_nib,
                         (r_b_mode != M_PLAIN), r_b_ch};

endmodule

FILE: sv/anf_checker.sv
// ----------------------------------------------------------------------------
// ADPCM nibble feeder port checker
// Checks result word consistency and output hold behavior at the ports.
// ----------------------------------------------------------------------------
`include "dual_adpcm_rom_nibble_feeder_top_macros.svh"

module anf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [anf_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata
);
    import anf_pkg::*;

    logic       nib_valid;
    logic [3:0] nib;
    logic       rst_strobe;
    logic       rst_level;

    assign nib_valid  = i_m_axis_tdata[1];
    assign nib        = i_m_axis_tdata[5:2];
    assign rst_strobe = i_m_axis_tdata[6];
    assign rst_level  = i_m_axis_tdata[7];

    `ANF_ASSERT_SAME(a_level_needs_strobe, i_clk, i_rst_n,
        i_m_axis_tvalid && rst_level, rst_strobe, "reset level without strobe")
    `ANF_ASSERT_SAME(a_quiet_nibble, i_clk, i_rst_n,
        i_m_axis_tvalid && !nib_valid, nib == 4'd0, "nibble set while not valid")
    `ANF_ASSERT_SAME(a_code_or_reset, i_clk, i_rst_n,
        i_m_axis_tvalid, !(nib_valid && rst_strobe), "code sent with decoder reset")
    `ANF_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n,
        i_m_axis_tvalid && !i_m_axis_tready,
        i_m_axis_tvalid && $stable(i_m_axis_tdata), "stalled word changed")

endmodule

bind dual_adpcm_rom_nibble_feeder_top anf_checker u_anf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
